FILE: hdl/bspt_pkg.sv
`default_nettype none

package bspt_pkg;

   localparam int MAX_SIDE_DEF = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int SIZE_W      = 5;
   localparam int COORD_W     = 5;
   localparam int VALUE_W     = 32;
   localparam int SUM_W       = 64;
   localparam int SIDE_W      = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/box_sum_prefix_table_3d.sv
// Three-dimensional summed-volume table with box-sum queries. A load request
// (action 0) stores the next cell, walking z fastest, then y, then x, up to the
// sizes in csr registers 0..2; loads after the table is full are accepted and
// dropped. A query request (action 1) returns one 64-bit wrapping box sum for
// one-based inclusive corners. Every prefix term is read from a single-ported
// table memory, one read per cycle, and folded in by one 64-bit add/subtract
// unit, so a load reads seven terms and then writes its sum, and a query reads
// eight terms before its response is registered; no new request is taken until
// the current one is through. A finished response waits in an output register
// while the next request is taken; a query that finishes while that register
// still holds a stalled response waits for it to go. There is no clearing pass
// after reset; queries are meant to follow a complete load of the table.
`default_nettype none

module box_sum_prefix_table_3d
   import bspt_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [SIZE_W-1:0]        csr_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_action,
   input  wire logic signed [VALUE_W-1:0] req_cell_value,
   input  wire logic [COORD_W-1:0]       req_lo_x,
   input  wire logic [COORD_W-1:0]       req_lo_y,
   input  wire logic [COORD_W-1:0]       req_lo_z,
   input  wire logic [COORD_W-1:0]       req_hi_x,
   input  wire logic [COORD_W-1:0]       req_hi_y,
   input  wire logic [COORD_W-1:0]       req_hi_z,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [SUM_W-1:0]       rsp_box_sum
);

   localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int CW = AW + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LAST = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   function automatic logic signed [CW-1:0] to_index(input logic [COORD_W-1:0] c);
      logic [SIDE_W-1:0] v;
      v = {2'b00, c};
      if (v > SIDE_W'(MAX_SIDE)) begin
         v = SIDE_W'(MAX_SIDE);
      end
      return CW'(v) - CW'(1);
   endfunction

   function automatic logic [SIDE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [SIDE_W-1:0] v;
      v = {2'b00, s};
      if (v == '0) begin
         v = SIDE_W'(1);
      end else if (v > SIDE_W'(MAX_SIDE)) begin
         v = SIDE_W'(MAX_SIDE);
      end
      return v;
   endfunction

   logic [1:0]              state_ff, state_in;
   logic [2:0]              term_ff, term_in;
   logic                    is_load_ff, is_load_in;
   logic signed [CW-1:0]    hi_x_ff, hi_x_in, hi_y_ff, hi_y_in, hi_z_ff, hi_z_in;
   logic signed [CW-1:0]    lo_x_ff, lo_x_in, lo_y_ff, lo_y_in, lo_z_ff, lo_z_in;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic                    pend_ff, pend_in;
   logic                    pend_zero_ff, pend_zero_in;
   logic                    pend_sub_ff, pend_sub_in;
   logic [AW-1:0]           pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic                    full_ff, full_in;
   logic [SIZE_W-1:0]       size_x_ff, size_x_in, size_y_ff, size_y_in;
   logic [SIZE_W-1:0]       size_z_ff, size_z_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]        rsp_sum_ff, rsp_sum_in;

   logic                    req_accept;
   logic [2:0]              term_sel;
   logic signed [CW-1:0]    tx, ty, tz;
   logic                    term_zero;
   logic [3*AW-1:0]         tbl_addr;
   logic                    tbl_we;
   logic [SUM_W-1:0]        tbl_rd;
   logic signed [CW-1:0]    pos_x_ext, pos_y_ext, pos_z_ext;
   logic [SIDE_W-1:0]       xp1, yp1, zp1;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // term k picks the low corner on x, y, z by bits 2, 1, 0
   assign term_sel  = (state_ff == ST_READ) ? term_ff : 3'b000;
   assign tx        = term_sel[2] ? lo_x_ff : hi_x_ff;
   assign ty        = term_sel[1] ? lo_y_ff : hi_y_ff;
   assign tz        = term_sel[0] ? lo_z_ff : hi_z_ff;
   assign term_zero = tx[CW-1] || ty[CW-1] || tz[CW-1];
   assign tbl_addr  = {tx[AW-1:0], ty[AW-1:0], tz[AW-1:0]};
   assign tbl_we    = (state_ff == ST_DONE) && is_load_ff;

   assign pos_x_ext = {2'b00, pos_x_ff};
   assign pos_y_ext = {2'b00, pos_y_ff};
   assign pos_z_ext = {2'b00, pos_z_ff};
   assign xp1 = {{(SIDE_W-AW){1'b0}}, pos_x_ff} + SIDE_W'(1);
   assign yp1 = {{(SIDE_W-AW){1'b0}}, pos_y_ff} + SIDE_W'(1);
   assign zp1 = {{(SIDE_W-AW){1'b0}}, pos_z_ff} + SIDE_W'(1);

   bspt_table #(
      .AW(AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .addr    (tbl_addr),
      .wr_data (acc_ff),
      .rd_data (tbl_rd)
   );

   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      is_load_in   = is_load_ff;
      hi_x_in      = hi_x_ff;
      hi_y_in      = hi_y_ff;
      hi_z_in      = hi_z_ff;
      lo_x_in      = lo_x_ff;
      lo_y_in      = lo_y_ff;
      lo_z_in      = lo_z_ff;
      acc_in       = acc_ff;
      pend_in      = 1'b0;
      pend_zero_in = term_zero;
      pend_sub_in  = (^term_ff) ^ is_load_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      full_in      = full_ff;
      size_x_in    = size_x_ff;
      size_y_in    = size_y_ff;
      size_z_in    = size_z_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_in = csr_data;
            CSR_SIZE_Y: size_y_in = csr_data;
            CSR_SIZE_Z: size_z_in = csr_data;
            default: ;
         endcase
      end

      // shared add/subtract unit
      if (pend_ff && !pend_zero_ff) begin
         acc_in = pend_sub_ff ? (acc_ff - tbl_rd) : (acc_ff + tbl_rd);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_action == ACTION_LOAD) begin
                  if (!full_ff) begin
                     is_load_in = 1'b1;
                     acc_in     = {{(SUM_W-VALUE_W){req_cell_value[VALUE_W-1]}},
                                   req_cell_value};
                     hi_x_in    = pos_x_ext;
                     hi_y_in    = pos_y_ext;
                     hi_z_in    = pos_z_ext;
                     lo_x_in    = pos_x_ext - CW'(1);
                     lo_y_in    = pos_y_ext - CW'(1);
                     lo_z_in    = pos_z_ext - CW'(1);
                     term_in    = 3'd1;
                     state_in   = ST_READ;
                  end
               end else begin
                  is_load_in = 1'b0;
                  acc_in     = '0;
                  hi_x_in    = to_index(req_hi_x);
                  hi_y_in    = to_index(req_hi_y);
                  hi_z_in    = to_index(req_hi_z);
                  lo_x_in    = to_index(req_lo_x) - CW'(1);
                  lo_y_in    = to_index(req_lo_y) - CW'(1);
                  lo_z_in    = to_index(req_lo_z) - CW'(1);
                  term_in    = 3'd0;
                  state_in   = ST_READ;
               end
            end
         end
         ST_READ: begin
            pend_in = 1'b1;
            if (term_ff == 3'd7) begin
               state_in = ST_LAST;
            end else begin
               term_in = term_ff + 3'd1;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (is_load_ff) begin
               state_in = ST_IDLE;
               if (zp1 >= eff_size(size_z_ff)) begin
                  pos_z_in = '0;
                  if (yp1 >= eff_size(size_y_ff)) begin
                     pos_y_in = '0;
                     if (xp1 >= eff_size(size_x_ff)) begin
                        pos_x_in = '0;
                        full_in  = 1'b1;
                     end else begin
                        pos_x_in = xp1[AW-1:0];
                     end
                  end else begin
                     pos_y_in = yp1[AW-1:0];
                  end
               end else begin
                  pos_z_in = zp1[AW-1:0];
               end
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= '0;
         pend_ff      <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         full_ff      <= 1'b0;
         size_x_ff    <= SIZE_RESET;
         size_y_ff    <= SIZE_RESET;
         size_z_ff    <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         pend_ff      <= pend_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
         full_ff      <= full_in;
         size_x_ff    <= size_x_in;
         size_y_ff    <= size_y_in;
         size_z_ff    <= size_z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_load_ff   <= is_load_in;
      hi_x_ff      <= hi_x_in;
      hi_y_ff      <= hi_y_in;
      hi_z_ff      <= hi_z_in;
      lo_x_ff      <= lo_x_in;
      lo_y_ff      <= lo_y_in;
      lo_z_ff      <= lo_z_in;
      acc_ff       <= acc_in;
      pend_zero_ff <= pend_zero_in;
      pend_sub_ff  <= pend_sub_in;
      rsp_sum_ff   <= rsp_sum_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_box_sum = rsp_sum_ff;

endmodule

`default_nettype wire

FILE: hdl/bspt_table.sv
`default_nettype none

module bspt_table
   import bspt_pkg::*;
#(
   parameter int AW = 4
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [3*AW-1:0]    addr,
   input  wire logic [SUM_W-1:0]   wr_data,
   output logic      [SUM_W-1:0]   rd_data
);

   localparam int DEPTH = 1 << (3 * AW);

   logic [SUM_W-1:0] mem [DEPTH];
   logic [SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/bspt_check.sv
`default_nettype none

module bspt_check
   import bspt_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     req_action,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [SUM_W-1:0]  rsp_box_sum
);

   // a stalled response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_box_sum))
      else $error("response changed while stalled");

   // a query keeps the block busy for its reads
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACTION_QUERY) |=> req_stall)
      else $error("query request did not occupy the block");

   // no response can appear right after a request is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("response raised too early");

endmodule

bind box_sum_prefix_table_3d bspt_check u_bspt_check (.*);

`default_nettype wire
